[hw/rtl/b64e_pkg.sv]
// shared types, constants and the alphabet lookup for the base64 stream encoder
// no dependencies
package b64e_pkg;

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);
   localparam int unsigned MaxChars   = 4;
   localparam int unsigned CharIdxW   = $clog2(MaxChars);

   localparam logic [6:0] PadChar = 7'h3D;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       last_char;
   } rsp_type;

   // characters caused by one input byte, emitted from index 0 up to last_idx
   typedef struct packed {
      logic [MaxChars-1:0][6:0] chars;
      logic [CharIdxW-1:0]      last_idx;
      logic                     ends_msg;
   } job_type;

   typedef enum logic [1:0] {
      PhaseFirst  = 2'd0,
      PhaseSecond = 2'd1,
      PhaseThird  = 2'd2
   } phase_type;

   function automatic logic [6:0] sextet_char(input logic [5:0] s);
      logic [6:0] c;
      if (s < 6'd26) begin
         c = 7'h41 + {1'b0, s};
      end else if (s < 6'd52) begin
         c = 7'h61 + {1'b0, s - 6'd26};
      end else if (s < 6'd62) begin
         c = 7'h30 + {1'b0, s - 6'd52};
      end else if (s == 6'd62) begin
         c = 7'h2B;
      end else begin
         c = 7'h2F;
      end
      return c;
   endfunction

endpackage

[hw/rtl/b64e_front.sv]
// front end: accepts bytes, tracks the group phase and leftover bits,
// and turns each byte into a job of one to four characters; uses b64e_pkg
module b64e_front
   import b64e_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   input  logic    queue_full,
   output logic    push,
   output job_type push_job
);

   phase_type  phase_ff, phase_in;
   logic [3:0] leftover_ff, leftover_in;
   logic       accept;
   logic [7:0] b;

   assign req_ready = !queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;
   assign b         = req_data.data_byte;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PhaseFirst;
         leftover_ff <= 4'd0;
      end else begin
         phase_ff    <= phase_in;
         leftover_ff <= leftover_in;
      end
   end

   always_comb begin
      phase_in    = phase_ff;
      leftover_in = leftover_ff;
      push_job    = '0;
      case (phase_ff)
         PhaseSecond: begin
            push_job.chars[0] = sextet_char({leftover_ff[1:0], b[7:4]});
            if (req_data.final_byte) begin
               push_job.chars[1] = sextet_char({b[3:0], 2'b00});
               push_job.chars[2] = PadChar;
               push_job.last_idx = CharIdxW'(2);
               push_job.ends_msg = 1'b1;
               if (accept) begin
                  phase_in    = PhaseFirst;
                  leftover_in = 4'd0;
               end
            end else if (accept) begin
               phase_in    = PhaseThird;
               leftover_in = b[3:0];
            end
         end
         PhaseThird: begin
            push_job.chars[0] = sextet_char({leftover_ff, b[7:6]});
            push_job.chars[1] = sextet_char(b[5:0]);
            push_job.last_idx = CharIdxW'(1);
            push_job.ends_msg = req_data.final_byte;
            if (accept) begin
               phase_in    = PhaseFirst;
               leftover_in = 4'd0;
            end
         end
         default: begin
            // start of a group
            push_job.chars[0] = sextet_char(b[7:2]);
            if (req_data.final_byte) begin
               push_job.chars[1] = sextet_char({b[1:0], 4'b0000});
               push_job.chars[2] = PadChar;
               push_job.chars[3] = PadChar;
               push_job.last_idx = CharIdxW'(3);
               push_job.ends_msg = 1'b1;
               if (accept) begin
                  phase_in    = PhaseFirst;
                  leftover_in = 4'd0;
               end
            end else if (accept) begin
               phase_in    = PhaseSecond;
               leftover_in = {2'b00, b[1:0]};
            end
         end
      endcase
   end

endmodule

[hw/rtl/b64e_queue.sv]
// short job queue between front and back ends; uses b64e_pkg
module b64e_queue
   import b64e_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   job_type                entries_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0]   count_ff, count_in;

   assign full       = (count_ff == QueueCntW'(QueueDepth));
   assign head_valid = (count_ff != '0);
   assign head_job   = entries_ff[rd_ptr_ff];

   function automatic logic [QueuePtrW-1:0] ptr_next(input logic [QueuePtrW-1:0] p);
      logic [QueuePtrW-1:0] n;
      if (p == QueuePtrW'(QueueDepth - 1)) begin
         n = '0;
      end else begin
         n = p + 1'b1;
      end
      return n;
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + QueueCntW'(push) - QueueCntW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[hw/rtl/b64e_back.sv]
// back end: walks the head job into the output register one character per cycle while
// that register is empty or being taken; uses b64e_pkg
module b64e_back
   import b64e_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    head_valid,
   input  job_type head_job,
   output logic    pop,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic [CharIdxW-1:0] idx_ff, idx_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;
   logic                load;
   logic                at_end;

   assign load   = head_valid && (!rsp_valid_ff || rsp_ready);
   assign at_end = (idx_ff == head_job.last_idx);
   assign pop    = load && at_end;

   always_comb begin
      idx_in       = idx_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load) begin
         rsp_valid_in       = 1'b1;
         rsp_in.out_char    = head_job.chars[idx_ff];
         rsp_in.last_char   = at_end && head_job.ends_msg;
         idx_in             = at_end ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/base64_stream_encoder.sv]
// Base64 stream encoder (standard alphabet, '=' padding). Takes one byte per item
// with a final flag and returns one ASCII character per result item, the last
// character of a message flagged with last_char. A byte is accepted in any cycle
// in which the two-entry job queue has room; each byte yields one to four
// characters and the back end sends one character per cycle, while the output is
// free or being taken, through a registered output, so the output port sets the
// sustained rate: four characters per three bytes on a long message. A byte's first
// character is registered in the job queue and then in the output register, behind
// any characters queued ahead of it.
// depends on b64e_pkg, b64e_front, b64e_queue, b64e_back
module base64_stream_encoder
   import b64e_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    push;
   job_type push_job;
   logic    queue_full;
   logic    pop;
   logic    head_valid;
   job_type head_job;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_job   (push_job)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_job   (push_job),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_job   (head_job)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_job   (head_job),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[sim/base64_stream_encoder_tb.sv]
// testbench for base64_stream_encoder: byte messages in, base64 characters out,
// checked against a character predictor kept in a small scoreboard class
// depends on b64e_pkg and the encoder rtl
`timescale 1ns / 100ps

module base64_stream_encoder_tb;
   import b64e_pkg::*;

   localparam int unsigned CycleLimit = 200000;

   class b64_char_scoreboard;
      const string alphabet =
         "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      phase_type   group_phase;
      logic [3:0]  leftover;
      rsp_type     expected_chars[$];
      int unsigned mismatch_count;

      function new();
         group_phase    = PhaseFirst;
         leftover       = '0;
         mismatch_count = 0;
      endfunction

      function logic [6:0] ascii_of(logic [5:0] s);
         byte c;
         c = alphabet[int'(s)];
         return c[6:0];
      endfunction

      function void add_char(logic [6:0] code, logic last);
         rsp_type r;
         r.out_char  = code;
         r.last_char = last;
         expected_chars.push_back(r);
      endfunction

      // works out the characters one accepted byte causes
      function void note_byte(req_type item);
         logic [7:0] b;
         logic       fin;
         b   = item.data_byte;
         fin = item.final_byte;
         case (group_phase)
            PhaseSecond: begin
               add_char(ascii_of({leftover[1:0], b[7:4]}), 1'b0);
               if (fin) begin
                  add_char(ascii_of({b[3:0], 2'b00}), 1'b0);
                  add_char(PadChar, 1'b1);
                  group_phase = PhaseFirst;
                  leftover    = '0;
               end else begin
                  leftover    = b[3:0];
                  group_phase = PhaseThird;
               end
            end
            PhaseThird: begin
               add_char(ascii_of({leftover, b[7:6]}), 1'b0);
               add_char(ascii_of(b[5:0]), fin);
               leftover    = '0;
               group_phase = PhaseFirst;
            end
            // an out-of-range phase behaves as a group start
            default: begin
               add_char(ascii_of(b[7:2]), 1'b0);
               if (fin) begin
                  add_char(ascii_of({b[1:0], 4'b0000}), 1'b0);
                  add_char(PadChar, 1'b0);
                  add_char(PadChar, 1'b1);
                  group_phase = PhaseFirst;
                  leftover    = '0;
               end else begin
                  leftover    = {2'b00, b[1:0]};
                  group_phase = PhaseSecond;
               end
            end
         endcase
      endfunction

      task report_mismatch(string what);
         $display("mismatch: %s", what);
         mismatch_count++;
      endtask

      task check_char(rsp_type got);
         rsp_type want;
         if (expected_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected char 0x%02h last %0d",
                                      got.out_char, got.last_char));
            return;
         end
         want = expected_chars.pop_front();
         if (got.out_char !== want.out_char)
            report_mismatch($sformatf("char 0x%02h, wanted 0x%02h",
                                      got.out_char, want.out_char));
         if (got.last_char !== want.last_char)
            report_mismatch($sformatf("last flag %0d, wanted %0d on char 0x%02h",
                                      got.last_char, want.last_char, want.out_char));
      endtask
   endclass

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int unsigned send_idle_pct = 20;
   int unsigned recv_idle_pct = 63;
   int unsigned cycle_count   = 0;

   b64_char_scoreboard char_sb = new();

   base64_stream_encoder i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) char_sb.note_byte(req_data);
         if (rsp_valid && rsp_ready) char_sb.check_char(rsp_data);
      end
   end

   task send_byte(input logic [7:0] b, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_data.data_byte  <= b;
      req_data.final_byte <= fin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task send_fixed(input logic [7:0] msg[$]);
      for (int i = 0; i < msg.size(); i++) send_byte(msg[i], i == msg.size() - 1);
   endtask

   function logic [7:0] pick_byte();
      int unsigned r;
      r = $urandom_range(0, 7);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // random messages until about the given number of items went in
   task send_random(input int unsigned item_goal);
      int unsigned sent;
      int unsigned len;
      sent = 0;
      while (sent < item_goal) begin
         if ($urandom_range(0, 9) == 0) len = $urandom_range(13, 30);
         else len = $urandom_range(1, 8);
         for (int i = 0; i < len; i++) send_byte(pick_byte(), i == len - 1);
         sent += len;
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // zero and all-ones bytes at every group position, '+' and '/' sextets
      send_fixed('{8'h00});
      send_fixed('{8'hFF});
      send_fixed('{8'h00, 8'h00});
      send_fixed('{8'hFF, 8'hFF});
      send_fixed('{8'h00, 8'h00, 8'h00});
      send_fixed('{8'hFB, 8'hEF, 8'hBE});
      send_fixed('{8'hFF, 8'hFF, 8'hFF});
      send_fixed('{8'h4D, 8'h61, 8'h6E, 8'h00, 8'h01, 8'h80, 8'h7F});

      send_random(36);
      send_idle_pct = 63;
      recv_idle_pct = 20;
      send_random(36);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_random(36);
      req_valid <= 1'b0;

      while (char_sb.expected_chars.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (char_sb.mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

[base64_stream_encoder.f]
hw/rtl/b64e_pkg.sv
hw/rtl/b64e_front.sv
hw/rtl/b64e_queue.sv
hw/rtl/b64e_back.sv
hw/rtl/base64_stream_encoder.sv
sim/base64_stream_encoder_tb.sv
